// ===== design/amo_pkg.sv =====
`default_nettype none

package amo_pkg;

	// default memory size in bytes
	localparam int unsigned MEM_BYTES_DEF = 32'd65536;

	// largest byte address before wrapping: (max offset + max index) * 4
	localparam int unsigned MAX_BASE = 32'd524280;
	localparam int unsigned BASE_W   = 19;

	// request codes
	localparam logic [3:0] RQ_ADD     = 4'd0;
	localparam logic [3:0] RQ_SUB     = 4'd1;
	localparam logic [3:0] RQ_AND     = 4'd2;
	localparam logic [3:0] RQ_OR      = 4'd3;
	localparam logic [3:0] RQ_XOR     = 4'd4;
	localparam logic [3:0] RQ_XCHG    = 4'd5;
	localparam logic [3:0] RQ_CMPXCHG = 4'd6;
	localparam logic [3:0] RQ_LOAD    = 4'd7;
	localparam logic [3:0] RQ_STORE   = 4'd8;

	// element type codes
	localparam logic [3:0] ET_I8   = 4'd0;
	localparam logic [3:0] ET_U8   = 4'd1;
	localparam logic [3:0] ET_U8C  = 4'd2;
	localparam logic [3:0] ET_I16  = 4'd3;
	localparam logic [3:0] ET_U16  = 4'd4;
	localparam logic [3:0] ET_I32  = 4'd5;
	localparam logic [3:0] ET_U32  = 4'd6;

	// element size codes (log2 of bytes)
	localparam logic [1:0] SZ_1 = 2'd0;
	localparam logic [1:0] SZ_2 = 2'd1;
	localparam logic [1:0] SZ_4 = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_TYPE  = 2'd2;

	typedef struct packed {
		logic [3:0]         req_type;
		logic [3:0]         elem_type;
		logic [15:0]        view_offset;
		logic [16:0]        view_length;
		logic signed [31:0] elem_index;
		logic signed [63:0] operand;
		logic signed [63:0] replacement;
	} req_t;

	typedef struct packed {
		logic signed [63:0] old_value;
		logic [1:0]         status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       clr;
		logic       red;
		logic       seek;
		logic       rd;
		logic       op;
		logic       wr;
		logic       out_load;
		logic [1:0] lane;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic       red_last;
		logic       bad;
		logic       do_wr;
		logic [1:0] sz;
	} stat_t;

	// number of conditional subtract steps that bring any base address below mem
	function automatic int unsigned red_steps(input int unsigned mem);
		int unsigned k;
		k = 0;
		for (int i = 0; i < 32; i++) begin
			if ((longint'(mem) << k) <= longint'(MAX_BASE)) begin
				k = k + 1;
			end
		end
		return k;
	endfunction

	// last byte lane of an element
	function automatic logic [1:0] last_lane(input logic [1:0] sz);
		logic [1:0] l;
		case (sz)
			SZ_1:    l = 2'd0;
			SZ_2:    l = 2'd1;
			default: l = 2'd3;
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

// ===== design/amo_stream_if.sv =====
`default_nettype none

interface amo_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/amo_dp.sv =====
`default_nettype none

module amo_dp #(
	parameter int unsigned MEM_BYTES = amo_pkg::MEM_BYTES_DEF,
	parameter int unsigned RED_STEPS = amo_pkg::red_steps(amo_pkg::MEM_BYTES_DEF)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire amo_pkg::cmd_t cmd,
	output amo_pkg::stat_t     st,
	input  wire amo_pkg::req_t req_data,
	output amo_pkg::rsp_t      rsp_data
);
	import amo_pkg::*;

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam int unsigned WW = (AW > BASE_W) ? AW : BASE_W;
	localparam int unsigned KW = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

	logic [7:0] mem [MEM_BYTES];

	logic [3:0]        req_type_q;
	logic              sgn_q;
	logic [1:0]        sz_q;
	logic [63:0]       opnd_q;
	logic [31:0]       repl_q;
	logic [1:0]        status_q;
	logic [WW-1:0]     red_q;
	logic [KW-1:0]     red_k_q;
	logic [AW-1:0]     addr_q;
	logic [31:0]       cur_q;
	logic [31:0]       nxt_q;
	logic              wr_q;
	logic signed [63:0] old_value_q;
	logic [1:0]        status_out_q;

	logic              type_ok;
	logic              type_sgn;
	logic [1:0]        type_sz;
	logic              idx_bad;
	logic [16:0]       sum;
	logic [BASE_W-1:0] base;
	logic [WW-1:0]     sub_val;
	logic [AW-1:0]     addr_inc;
	logic [31:0]       mask;
	logic [31:0]       nxt;
	logic              wr;
	logic [63:0]       ext;

	// element type decode
	always_comb begin
		type_ok  = 1'b1;
		type_sgn = 1'b0;
		type_sz  = SZ_1;
		case (req_data.elem_type)
			ET_I8:   type_sgn = 1'b1;
			ET_U8:   type_sgn = 1'b0;
			ET_U8C:  type_sgn = 1'b0;
			ET_I16: begin
				type_sgn = 1'b1;
				type_sz  = SZ_2;
			end
			ET_U16:  type_sz = SZ_2;
			ET_I32: begin
				type_sgn = 1'b1;
				type_sz  = SZ_4;
			end
			ET_U32:  type_sz = SZ_4;
			default: type_ok = 1'b0;
		endcase
	end

	// bounds check and byte address of the element
	assign idx_bad = req_data.elem_index[31] ||
		($unsigned(req_data.elem_index) >= {15'd0, req_data.view_length});
	assign sum = {1'b0, req_data.view_offset} + {1'b0, req_data.elem_index[15:0]};
	always_comb begin
		case (type_sz)
			SZ_1:    base = {2'd0, sum};
			SZ_2:    base = {1'b0, sum, 1'b0};
			default: base = {sum, 2'd0};
		endcase
	end

	assign sub_val  = WW'(MEM_BYTES) << red_k_q;
	assign addr_inc = (addr_q == AW'(MEM_BYTES - 1)) ? '0 : addr_q + AW'(1);

	// element mask and operation
	always_comb begin
		case (sz_q)
			SZ_1:    mask = 32'h0000_00ff;
			SZ_2:    mask = 32'h0000_ffff;
			default: mask = 32'hffff_ffff;
		endcase
	end

	always_comb begin
		nxt = cur_q;
		wr  = 1'b1;
		case (req_type_q)
			RQ_ADD:     nxt = cur_q + opnd_q[31:0];
			RQ_SUB:     nxt = cur_q - opnd_q[31:0];
			RQ_AND:     nxt = cur_q & opnd_q[31:0];
			RQ_OR:      nxt = cur_q | opnd_q[31:0];
			RQ_XOR:     nxt = cur_q ^ opnd_q[31:0];
			RQ_XCHG:    nxt = opnd_q[31:0];
			RQ_CMPXCHG: begin
				nxt = repl_q;
				wr  = ((opnd_q[31:0] & mask) == cur_q);
			end
			RQ_STORE:   nxt = opnd_q[31:0];
			default:    wr = 1'b0;
		endcase
	end

	// prior value extended by type
	always_comb begin
		case (sz_q)
			SZ_1:    ext = {{56{sgn_q & cur_q[7]}}, cur_q[7:0]};
			SZ_2:    ext = {{48{sgn_q & cur_q[15]}}, cur_q[15:0]};
			default: ext = {{32{sgn_q & cur_q[31]}}, cur_q};
		endcase
	end

	// request capture and address reduction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_data.req_type;
			sgn_q      <= type_sgn;
			sz_q       <= type_sz;
			opnd_q     <= req_data.operand;
			repl_q     <= req_data.replacement[31:0];
			status_q   <= !type_ok ? ST_TYPE : (idx_bad ? ST_RANGE : ST_OK);
			red_q      <= WW'(base);
			red_k_q    <= KW'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
		end else if (cmd.red) begin
			if (red_q >= sub_val) begin
				red_q <= red_q - sub_val;
			end
			red_k_q <= red_k_q - KW'(1);
		end
	end

	// memory address pointer, also the clearing pointer after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.seek) begin
			addr_q <= red_q[AW-1:0];
		end else if (cmd.rd || cmd.wr || cmd.clr) begin
			addr_q <= addr_inc;
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[addr_q] <= 8'd0;
		end else if (cmd.wr) begin
			mem[addr_q] <= nxt_q[cmd.lane*8 +: 8];
		end
	end

	// memory read port into the byte lane of the current value
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= '0;
		end else if (cmd.rd) begin
			cur_q[cmd.lane*8 +: 8] <= mem[addr_q];
		end
	end

	// new value and write decision
	always_ff @(posedge clk) begin
		if (cmd.op) begin
			nxt_q <= nxt;
			wr_q  <= wr;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_out_q <= status_q;
			if (status_q != ST_OK) begin
				old_value_q <= '0;
			end else if (req_type_q == RQ_STORE) begin
				old_value_q <= opnd_q;
			end else begin
				old_value_q <= ext;
			end
		end
	end

	assign rsp_data.old_value = old_value_q;
	assign rsp_data.status    = status_out_q;

	assign st.clr_last = (addr_q == AW'(MEM_BYTES - 1));
	assign st.red_last = (red_k_q == '0);
	assign st.bad      = (status_q != ST_OK);
	assign st.do_wr    = wr_q;
	assign st.sz       = sz_q;

endmodule

`default_nettype wire

// ===== design/amo_ctrl.sv =====
`default_nettype none

module amo_ctrl #(
	parameter int unsigned RED_STEPS = amo_pkg::red_steps(amo_pkg::MEM_BYTES_DEF)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output amo_pkg::cmd_t       cmd,
	input  wire amo_pkg::stat_t st
);
	import amo_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RED,
		S_SEEK,
		S_RD,
		S_OP,
		S_WR,
		S_FIN
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] cnt_q;
	logic       out_valid_q;
	logic       last;

	assign last      = (cnt_q == last_lane(st.sz));
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	// command decode and next state
	always_comb begin
		cmd      = '0;
		cmd.lane = cnt_q;
		state_d  = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (RED_STEPS > 0) ? S_RED : S_SEEK;
				end
			end
			S_RED: begin
				if (st.bad) begin
					state_d = S_FIN;
				end else begin
					cmd.red = 1'b1;
					if (st.red_last) begin
						state_d = S_SEEK;
					end
				end
			end
			S_SEEK: begin
				if (st.bad) begin
					state_d = S_FIN;
				end else begin
					cmd.seek = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				if (last) begin
					state_d = S_OP;
				end
			end
			S_OP: begin
				cmd.op   = 1'b1;
				cmd.seek = 1'b1;
				state_d  = S_WR;
			end
			S_WR: begin
				if (!st.do_wr) begin
					state_d = S_FIN;
				end else begin
					cmd.wr = 1'b1;
					if (last) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, byte counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rd || cmd.wr) begin
				cnt_q <= last ? 2'd0 : cnt_q + 2'd1;
			end else if (cmd.seek) begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// memory is only written for in-range integer elements
	a_wr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !st.bad)
		else $error("memory write for a rejected item");

	// byte counter stays inside the element
	a_lane_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd || cmd.wr) |-> (cnt_q <= last_lane(st.sz)))
		else $error("byte lane beyond element size");

	// an accepted item leaves idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q != S_IDLE))
		else $error("controller idle after accepting an item");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== design/atomic_memory_op_unit.sv =====
`default_nettype none

// sequence: accept item, reduce the address in R wrap steps (3 at 64 KiB, 0 from 512 KiB up),
//   read the N element bytes (1, 2 or 4) over the byte-wide memory port, apply the operation,
//   write them back if the element is written and register the result; rejected items skip memory
// items are taken one at a time: a new item is accepted only once the last result is loaded
// reset: asynchronous, active low; then a clearing pass zeroes the memory
//   while no item is accepted
module atomic_memory_op_unit #(
	parameter int unsigned MEM_BYTES = amo_pkg::MEM_BYTES_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	amo_stream_if.sink   req,
	amo_stream_if.source rsp
);
	import amo_pkg::*;

	localparam int unsigned RED_STEPS = red_steps(MEM_BYTES);

	cmd_t  cmd;
	stat_t st;

	// sequencing of clear, read, modify and write-back
	amo_ctrl #(
		.RED_STEPS(RED_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	// memory, address and operation datapath
	amo_dp #(
		.MEM_BYTES (MEM_BYTES),
		.RED_STEPS (RED_STEPS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.req_data (req.data),
		.rsp_data (rsp.data)
	);

endmodule

`default_nettype wire
